// File: hdl/job_slot_pool_defines.svh
// Assertion helpers used by the checker file jsp_checker.sv.
`ifndef JOB_SLOT_POOL_DEFINES_SVH
`define JOB_SLOT_POOL_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define JSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define JSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/jsp_pkg.sv
`default_nettype none

package jsp_pkg;

    localparam int MAX_SLOTS = 16;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int LINK_W    = $clog2(MAX_SLOTS + 1);

    localparam int REQ_W = 3;
    localparam int ID_W  = 4;
    localparam int PAY_W = 32;
    localparam int CNT_W = 5;

    typedef logic [LINK_W-1:0] t_link;
    typedef logic [SLOT_W-1:0] t_slot;

    localparam t_link NIL = LINK_W'(MAX_SLOTS);

    localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_TAKE   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FINISH = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

endpackage

`default_nettype wire

// File: hdl/jsp_ram.sv
`default_nettype none

module jsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hdl/job_slot_pool.sv
// job_slot_pool: pool of MAX_SLOTS job slots kept as a free stack and a
// pending stack, linked through one link memory; payloads sit in a second
// memory.
// Requests: drive i_req_type, i_slot_id, i_job_payload with start high; the
// request is taken at the clock edge where start is high and busy is low.
// Each request yields exactly one result, shown for one cycle with o_done
// high; the receiver must take it then, it cannot hold results off.
// The counts on o_free_count, o_pending_count, o_active_count are valid
// while o_done is high and change only at the edge that raises o_done.
// States passed, from the accepting edge to the edge that raises o_done:
//   add, take, finish, empty remove, empty clear, unused codes: S_HEAD.
//   remove: S_RM_WAIT walks the pending list from the head, then S_RM_FREE if found.
//   remove not found: S_RM_WAIT until the end of the pending list.
//   clear: S_CLR_WAIT moves each pending slot to the free stack.
// A new request may be accepted in the cycle o_done is high. The one read
// port of the link memory sets the pace: one list step per cycle, with
// registered reads.
// Reset (i_rst_n low at a clock edge): all slots free, nothing pending or
// active; link entries read as their reset chain until first written.
`default_nettype none

module job_slot_pool (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [jsp_pkg::REQ_W-1:0]  i_req_type,
    input  wire logic [jsp_pkg::ID_W-1:0]   i_slot_id,
    input  wire logic [jsp_pkg::PAY_W-1:0]  i_job_payload,
    output logic                            o_done,
    output logic                            o_ok,
    output logic      [jsp_pkg::ID_W-1:0]   o_slot_out,
    output logic      [jsp_pkg::PAY_W-1:0]  o_payload_out,
    output logic      [jsp_pkg::CNT_W-1:0]  o_free_count,
    output logic      [jsp_pkg::CNT_W-1:0]  o_pending_count,
    output logic      [jsp_pkg::CNT_W-1:0]  o_active_count
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_HEAD     = 3'd1;
    localparam logic [2:0] S_RM_WAIT  = 3'd2;
    localparam logic [2:0] S_RM_FREE  = 3'd3;
    localparam logic [2:0] S_CLR_WAIT = 3'd4;

    logic [2:0] r_state, n_state;
    jsp_pkg::t_link r_free_head, n_free_head;
    jsp_pkg::t_link r_pend_head, n_pend_head;
    jsp_pkg::t_link r_pend_total, n_pend_total;
    jsp_pkg::t_link r_act_total, n_act_total;
    logic [jsp_pkg::MAX_SLOTS-1:0] r_link_vld, n_link_vld;
    logic [jsp_pkg::MAX_SLOTS-1:0] r_active, n_active;
    logic r_done, n_done;

    logic [jsp_pkg::REQ_W-1:0] r_req, n_req;
    logic [jsp_pkg::ID_W-1:0]  r_sid, n_sid;
    logic [jsp_pkg::PAY_W-1:0] r_pay, n_pay;
    jsp_pkg::t_link r_cur, n_cur;
    jsp_pkg::t_link r_prev, n_prev;
    jsp_pkg::t_link r_cnt, n_cnt;
    jsp_pkg::t_slot r_rd_addr;
    logic r_rd_vld;
    logic r_ok, n_ok;
    logic [jsp_pkg::ID_W-1:0]  r_slot, n_slot;
    logic [jsp_pkg::PAY_W-1:0] r_pout, n_pout;

    logic                      link_we;
    jsp_pkg::t_slot            link_waddr;
    jsp_pkg::t_link            link_wdata;
    jsp_pkg::t_slot            link_raddr;
    jsp_pkg::t_link            link_ram_q;
    jsp_pkg::t_link            link_q;
    logic                      pay_we;
    logic [jsp_pkg::PAY_W-1:0] pay_q;

    logic           sid_in_range;
    jsp_pkg::t_slot sid_slot;
    logic           rm_hit;
    jsp_pkg::t_link cnt_inc;

    jsp_ram #(
        .WIDTH(jsp_pkg::LINK_W),
        .DEPTH(jsp_pkg::MAX_SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_ram_q)
    );

    jsp_ram #(
        .WIDTH(jsp_pkg::PAY_W),
        .DEPTH(jsp_pkg::MAX_SLOTS)
    ) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_waddr (link_waddr),
        .i_wdata (r_pay),
        .i_raddr (link_raddr),
        .o_rdata (pay_q)
    );

    // never-written link entries hold the reset chain
    assign link_q = r_rd_vld ? link_ram_q
                             : jsp_pkg::LINK_W'(r_rd_addr) + jsp_pkg::LINK_W'(1);

    assign sid_in_range = (int'(r_sid) < jsp_pkg::MAX_SLOTS);
    assign sid_slot     = jsp_pkg::SLOT_W'(r_sid);
    assign rm_hit       = sid_in_range && (r_cur == jsp_pkg::LINK_W'(r_sid));
    assign cnt_inc      = r_cnt + jsp_pkg::LINK_W'(1);

    always_comb begin
        n_state      = r_state;
        n_free_head  = r_free_head;
        n_pend_head  = r_pend_head;
        n_pend_total = r_pend_total;
        n_act_total  = r_act_total;
        n_link_vld   = r_link_vld;
        n_active     = r_active;
        n_done       = 1'b0;
        n_req        = r_req;
        n_sid        = r_sid;
        n_pay        = r_pay;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_cnt        = r_cnt;
        n_ok         = r_ok;
        n_slot       = r_slot;
        n_pout       = r_pout;
        link_we      = 1'b0;
        link_waddr   = r_cur[jsp_pkg::SLOT_W-1:0];
        link_wdata   = r_free_head;
        link_raddr   = r_cur[jsp_pkg::SLOT_W-1:0];
        pay_we       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req  = i_req_type;
                    n_sid  = i_slot_id;
                    n_pay  = i_job_payload;
                    n_cur  = r_pend_head;
                    n_prev = jsp_pkg::NIL;
                    n_cnt  = '0;
                    if (i_req_type == jsp_pkg::REQ_ADD) begin
                        link_raddr = r_free_head[jsp_pkg::SLOT_W-1:0];
                    end else begin
                        link_raddr = r_pend_head[jsp_pkg::SLOT_W-1:0];
                    end
                    if (i_req_type == jsp_pkg::REQ_REMOVE && r_pend_head != jsp_pkg::NIL) begin
                        n_state = S_RM_WAIT;
                    end else if (i_req_type == jsp_pkg::REQ_CLEAR &&
                                 r_pend_head != jsp_pkg::NIL) begin
                        n_state = S_CLR_WAIT;
                    end else begin
                        n_state = S_HEAD;
                    end
                end
            end
            S_HEAD: begin
                n_ok    = 1'b0;
                n_slot  = '0;
                n_pout  = '0;
                n_done  = 1'b1;
                n_state = S_IDLE;
                case (r_req)
                    jsp_pkg::REQ_ADD: begin
                        if (r_free_head != jsp_pkg::NIL) begin
                            link_we      = 1'b1;
                            pay_we       = 1'b1;
                            link_waddr   = r_free_head[jsp_pkg::SLOT_W-1:0];
                            link_wdata   = r_pend_head;
                            n_free_head  = link_q;
                            n_pend_head  = r_free_head;
                            n_pend_total = r_pend_total + jsp_pkg::LINK_W'(1);
                            n_ok         = 1'b1;
                            n_slot       = jsp_pkg::ID_W'(r_free_head);
                        end
                    end
                    jsp_pkg::REQ_TAKE: begin
                        if (r_pend_head != jsp_pkg::NIL) begin
                            n_pend_head  = link_q;
                            n_pend_total = r_pend_total - jsp_pkg::LINK_W'(1);
                            n_act_total  = r_act_total + jsp_pkg::LINK_W'(1);
                            n_active[r_pend_head[jsp_pkg::SLOT_W-1:0]] = 1'b1;
                            n_ok         = 1'b1;
                            n_slot       = jsp_pkg::ID_W'(r_pend_head);
                            n_pout       = pay_q;
                        end
                    end
                    jsp_pkg::REQ_FINISH: begin
                        if (r_act_total != '0 && sid_in_range && r_active[sid_slot]) begin
                            n_active[sid_slot] = 1'b0;
                            n_act_total = r_act_total - jsp_pkg::LINK_W'(1);
                            link_we     = 1'b1;
                            link_waddr  = sid_slot;
                            link_wdata  = r_free_head;
                            n_free_head = jsp_pkg::LINK_W'(r_sid);
                            n_ok        = 1'b1;
                        end
                    end
                    jsp_pkg::REQ_CLEAR: begin
                        n_ok = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_RM_WAIT: begin
                if (rm_hit) begin
                    if (r_prev == jsp_pkg::NIL) begin
                        n_pend_head = link_q;
                    end else begin
                        link_we    = 1'b1;
                        link_waddr = r_prev[jsp_pkg::SLOT_W-1:0];
                        link_wdata = link_q;
                    end
                    n_state = S_RM_FREE;
                end else begin
                    n_prev = r_cur;
                    n_cur  = link_q;
                    n_cnt  = cnt_inc;
                    link_raddr = link_q[jsp_pkg::SLOT_W-1:0];
                    if (link_q == jsp_pkg::NIL || cnt_inc == jsp_pkg::NIL) begin
                        n_ok    = 1'b0;
                        n_slot  = '0;
                        n_pout  = '0;
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_RM_FREE: begin
                link_we      = 1'b1;
                link_waddr   = r_cur[jsp_pkg::SLOT_W-1:0];
                link_wdata   = r_free_head;
                n_free_head  = r_cur;
                n_pend_total = r_pend_total - jsp_pkg::LINK_W'(1);
                n_ok         = 1'b1;
                n_slot       = '0;
                n_pout       = '0;
                n_done       = 1'b1;
                n_state      = S_IDLE;
            end
            S_CLR_WAIT: begin
                link_we     = 1'b1;
                link_waddr  = r_cur[jsp_pkg::SLOT_W-1:0];
                link_wdata  = r_free_head;
                n_free_head = r_cur;
                n_pend_head = link_q;
                n_cnt       = cnt_inc;
                n_cur       = link_q;
                link_raddr  = link_q[jsp_pkg::SLOT_W-1:0];
                if (link_q == jsp_pkg::NIL || cnt_inc == jsp_pkg::NIL) begin
                    n_pend_head  = jsp_pkg::NIL;
                    n_pend_total = '0;
                    n_ok         = 1'b1;
                    n_slot       = '0;
                    n_pout       = '0;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (link_we) begin
            n_link_vld[link_waddr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_head  <= '0;
            r_pend_head  <= jsp_pkg::NIL;
            r_pend_total <= '0;
            r_act_total  <= '0;
            r_link_vld   <= '0;
            r_active     <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_head  <= n_free_head;
            r_pend_head  <= n_pend_head;
            r_pend_total <= n_pend_total;
            r_act_total  <= n_act_total;
            r_link_vld   <= n_link_vld;
            r_active     <= n_active;
            r_done       <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_sid     <= n_sid;
        r_pay     <= n_pay;
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_cnt     <= n_cnt;
        r_ok      <= n_ok;
        r_slot    <= n_slot;
        r_pout    <= n_pout;
        r_rd_addr <= link_raddr;
        r_rd_vld  <= r_link_vld[link_raddr];
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_ok            = r_ok;
    assign o_slot_out      = r_slot;
    assign o_payload_out   = r_pout;
    assign o_pending_count = jsp_pkg::CNT_W'(r_pend_total);
    assign o_active_count  = jsp_pkg::CNT_W'(r_act_total);
    assign o_free_count    = jsp_pkg::CNT_W'(jsp_pkg::NIL - r_pend_total - r_act_total);

endmodule

`default_nettype wire

// File: hdl/jsp_checker.sv
`default_nettype none

`include "job_slot_pool_defines.svh"

module jsp_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic                      o_done,
    input wire logic [jsp_pkg::CNT_W-1:0] o_free_count,
    input wire logic [jsp_pkg::CNT_W-1:0] o_pending_count,
    input wire logic [jsp_pkg::CNT_W-1:0] o_active_count
);

    logic [jsp_pkg::CNT_W+1:0] count_sum;

    assign count_sum = (jsp_pkg::CNT_W+2)'(o_free_count) + (jsp_pkg::CNT_W+2)'(o_pending_count)
                     + (jsp_pkg::CNT_W+2)'(o_active_count);

    `JSP_ASSERT_IMP(a_count_sum, i_clk, i_rst_n, 1'b1, count_sum == (jsp_pkg::CNT_W+2)'(jsp_pkg::MAX_SLOTS), "slot counts do not add up to the pool size")
    `JSP_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accepted request did not raise busy")
    `JSP_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !busy, "result shown while still busy")
    `JSP_ASSERT_NXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "result strobe held for two cycles")
    `JSP_ASSERT_IMP(a_counts_hold, i_clk, i_rst_n, !o_done && $past(i_rst_n), $stable(o_pending_count) && $stable(o_active_count), "counts moved without a result")

endmodule

bind job_slot_pool jsp_checker u_jsp_checker (.*);

`default_nettype wire
